>>> sv/qmm_pkg.sv
// Shared types, constants and the saturation function for the quad X motor mixer with arming control.
// No dependencies; imported by quad_motor_mixer_arming.
`timescale 1ns / 1ps
`default_nettype none

package qmm_pkg;

    localparam int THR_W   = 12;
    localparam int DRIVE_W = 16;
    localparam int SUM_W   = DRIVE_W + 2;
    localparam int BASE_W  = DRIVE_W + 1;
    localparam int CFG_AW  = 2;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 72;

    // Register indexes on the configuration port
    localparam logic [CFG_AW-1:0] REG_ARM_THRESHOLD   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_IDLE_CUTOFF     = 2'd1;
    localparam logic [CFG_AW-1:0] REG_THROTTLE_OFFSET = 2'd2;
    localparam logic [CFG_AW-1:0] REG_BASE_LIMIT      = 2'd3;

    localparam logic [THR_W-1:0] RST_ARM_THRESHOLD   = 12'd1100;
    localparam logic [THR_W-1:0] RST_IDLE_CUTOFF     = 12'd1040;
    localparam logic [THR_W-1:0] RST_THROTTLE_OFFSET = 12'd1000;
    localparam logic [THR_W-1:0] RST_BASE_LIMIT      = 12'd800;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] yaw_drive;
        logic signed [DRIVE_W-1:0] pitch_drive;
        logic signed [DRIVE_W-1:0] roll_drive;
        logic signed [DRIVE_W-1:0] height_drive;
        logic [THR_W-1:0]          throttle;
        logic                      hold_req;
        logic                      takeoff_req;
        logic                      armed;
    } ctrl_word_t;

    typedef struct packed {
        logic                      hold_next;
        logic                      takeoff_next;
        logic signed [DRIVE_W-1:0] motor_four;
        logic signed [DRIVE_W-1:0] motor_three;
        logic signed [DRIVE_W-1:0] motor_two;
        logic signed [DRIVE_W-1:0] motor_one;
    } mix_word_t;

    // Clip a widened mixer sum to the 16-bit signed range
    function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(signed'({1'b0, {(DRIVE_W-1){1'b1}}}));
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return {1'b0, {(DRIVE_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            return v[DRIVE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/quad_motor_mixer_arming.sv
// Top level: arming state machine and X-quad motor mixer, one word per cycle while the result side keeps up.
// Depends on qmm_pkg for word layouts, register indexes and saturation.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake                 Payload
//  s_        in         s_tvalid / s_tready       s_tdata: control tick word (80 bits)
//  m_        out        m_tvalid / m_tready       m_tdata: motor levels and flags (72 bits)
//  cfg_      in         cfg_wr_en (no wait)       cfg_addr, cfg_wdata: tuning registers
//
//  Each accepted word is held in the input register, then the arming/mix logic
//  writes its result into the result register when that slot is free. A new word
//  is taken every cycle while the result side keeps up; a stalled result holds
//  and the input register still absorbs one more word. aresetn (synchronous)
//  returns the phase to waiting-for-arm, zeroes the held motor levels and
//  restores the register defaults.

module quad_motor_mixer_arming (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // armed, takeoff_req, hold_req, throttle[11:0], height_drive, roll_drive,
    // pitch_drive, yaw_drive, zero pad
    input  wire  [qmm_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // motor_one, motor_two, motor_three, motor_four, takeoff_next, hold_next,
    // zero pad
    output logic [qmm_pkg::M_DATA_W-1:0] m_tdata,
    input  wire                          cfg_wr_en,
    input  wire  [qmm_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire  [qmm_pkg::THR_W-1:0]    cfg_wdata
);

    import qmm_pkg::*;

    localparam logic [1:0] PH_WAIT_ARM   = 2'd0;
    localparam logic [1:0] PH_WAIT_STICK = 2'd1;
    localparam logic [1:0] PH_FLY        = 2'd2;
    localparam logic [1:0] PH_STOP       = 2'd3;

    // Tuning registers
    logic [THR_W-1:0] arm_threshold_reg;
    logic [THR_W-1:0] idle_cutoff_reg;
    logic [THR_W-1:0] throttle_offset_reg;
    logic [THR_W-1:0] base_limit_reg;

    // Pipeline registers
    logic       in_valid_reg;
    ctrl_word_t in_word_reg;
    logic       out_valid_reg;
    mix_word_t  out_word_reg;

    // Machine state
    logic [1:0]                phase_reg;
    logic [1:0]                phase_next;
    logic signed [DRIVE_W-1:0] level_reg [4];
    logic signed [DRIVE_W-1:0] level_next [4];

    logic advance;
    logic takeoff_eff;
    logic hold_eff;
    logic fly;
    logic zero_all;
    logic run_mix;

    logic signed [BASE_W-1:0] base_raw;
    logic signed [BASE_W-1:0] base_clamped;
    logic signed [SUM_W-1:0]  base_x;
    logic signed [SUM_W-1:0]  roll_x;
    logic signed [SUM_W-1:0]  pitch_x;
    logic signed [SUM_W-1:0]  yaw_x;
    logic signed [THR_W:0]    thr_minus_off;

    // Move the held word into the result register when that slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(mix_word_t)){1'b0}}, out_word_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_threshold_reg   <= RST_ARM_THRESHOLD;
            idle_cutoff_reg     <= RST_IDLE_CUTOFF;
            throttle_offset_reg <= RST_THROTTLE_OFFSET;
            base_limit_reg      <= RST_BASE_LIMIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ARM_THRESHOLD:   arm_threshold_reg   <= cfg_wdata;
                REG_IDLE_CUTOFF:     idle_cutoff_reg     <= cfg_wdata;
                REG_THROTTLE_OFFSET: throttle_offset_reg <= cfg_wdata;
                REG_BASE_LIMIT:      base_limit_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Arming sequence: decide phase, flags and whether the mixer runs
    always_comb begin
        phase_next  = phase_reg;
        takeoff_eff = in_word_reg.takeoff_req;
        hold_eff    = in_word_reg.hold_req;
        fly         = 1'b0;
        zero_all    = 1'b0;
        if (!in_word_reg.armed) begin
            // disarm: stop now, back to waiting next tick
            zero_all   = 1'b1;
            phase_next = PH_WAIT_ARM;
        end else begin
            unique case (phase_reg)
                PH_WAIT_ARM: begin
                    // clear flags, then stick check in the same tick
                    zero_all    = 1'b1;
                    takeoff_eff = 1'b0;
                    hold_eff    = 1'b0;
                    if (in_word_reg.throttle > arm_threshold_reg) begin
                        phase_next = PH_FLY;
                        fly        = 1'b1;
                    end else begin
                        phase_next = PH_WAIT_STICK;
                    end
                end
                PH_WAIT_STICK: begin
                    priority if (in_word_reg.throttle > arm_threshold_reg
                                 && !in_word_reg.takeoff_req) begin
                        phase_next = PH_FLY;
                        fly        = 1'b1;
                    end else if (in_word_reg.takeoff_req) begin
                        hold_eff   = 1'b1;
                        phase_next = PH_FLY;
                        fly        = 1'b1;
                    end else begin
                        phase_next = PH_WAIT_STICK;
                    end
                end
                PH_FLY: begin
                    fly = 1'b1;
                end
                PH_STOP: begin
                    zero_all   = 1'b1;
                    phase_next = PH_WAIT_ARM;
                end
                default: ;
            endcase
        end
    end

    // Base thrust: height drive in hold, else throttle less offset with idle cutoff; clamped to 0..base limit
    assign thr_minus_off = signed'({1'b0, in_word_reg.throttle})
                         - signed'({1'b0, throttle_offset_reg});

    always_comb begin
        run_mix = fly;
        if (hold_eff) begin
            base_raw = BASE_W'(in_word_reg.height_drive);
        end else if (in_word_reg.throttle < idle_cutoff_reg) begin
            base_raw = '0;
            if (fly) begin
                run_mix = 1'b0;
            end
        end else begin
            base_raw = BASE_W'(thr_minus_off);
        end
        if (base_raw < 0) begin
            base_clamped = '0;
        end else if (base_raw > signed'(BASE_W'({1'b0, base_limit_reg}))) begin
            base_clamped = BASE_W'({1'b0, base_limit_reg});
        end else begin
            base_clamped = base_raw;
        end
    end

    assign base_x  = SUM_W'(base_clamped);
    assign roll_x  = SUM_W'(in_word_reg.roll_drive);
    assign pitch_x = SUM_W'(in_word_reg.pitch_drive);
    assign yaw_x   = SUM_W'(in_word_reg.yaw_drive);

    // Mix by X-quad signs; hold levels when nothing changes them
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            level_next[i] = level_reg[i];
        end
        if (zero_all || (fly && !run_mix)) begin
            for (int i = 0; i < 4; i++) begin
                level_next[i] = '0;
            end
        end
        if (run_mix) begin
            level_next[0] = sat_drive(base_x + roll_x - pitch_x - yaw_x);
            level_next[1] = sat_drive(base_x + roll_x + pitch_x + yaw_x);
            level_next[2] = sat_drive(base_x - roll_x + pitch_x - yaw_x);
            level_next[3] = sat_drive(base_x - roll_x - pitch_x + yaw_x);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_WAIT_ARM;
            for (int i = 0; i < 4; i++) begin
                level_reg[i] <= '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                for (int i = 0; i < 4; i++) begin
                    level_reg[i] <= level_next[i];
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= ctrl_word_t'(s_tdata[$bits(ctrl_word_t)-1:0]);
        end
        if (advance) begin
            out_word_reg.motor_one    <= level_next[0];
            out_word_reg.motor_two    <= level_next[1];
            out_word_reg.motor_three  <= level_next[2];
            out_word_reg.motor_four   <= level_next[3];
            out_word_reg.takeoff_next <= takeoff_eff;
            out_word_reg.hold_next    <= hold_eff;
        end
    end

endmodule

`default_nettype wire
